>>> src/bhr_pkg.sv
// ----------------------------------------------------------------------------
// bhr_pkg
// Shared widths, constants and types for the breathing HSV-to-RGB pipeline.
// ----------------------------------------------------------------------------
package bhr_pkg;

  localparam int ChanW     = 8;   // hue, saturation and color channels
  localparam int TimeW     = 16;  // millisecond time input
  localparam int PhaseLsb  = 4;   // phase = time_ms[PhaseLsb +: ChanW]
  localparam int NumStages = 4;   // register stages from input to output word

  localparam logic [ChanW-1:0] LevelBase = 8'd80;  // brightness floor

  // Sixth of the color wheel that a hue falls into
  typedef enum logic [2:0] {
    RgnRedYellow     = 3'd0,
    RgnYellowGreen   = 3'd1,
    RgnGreenCyan     = 3'd2,
    RgnCyanBlue      = 3'd3,
    RgnBlueMagenta   = 3'd4,
    RgnMagentaRed    = 3'd5
  } hue_region_e;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_load_t;

endpackage

>>> src/bhr_intf.sv
// ----------------------------------------------------------------------------
// bhr_hsv_if / bhr_rgb_if
// Valid/ready channels: HSV-plus-time words in, RGB words out.
// ----------------------------------------------------------------------------
interface bhr_hsv_if;
  import bhr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ChanW-1:0]     hue;
  logic [ChanW-1:0]     saturation;
  logic [TimeW-1:0]     time_ms;

  modport source (output valid, hue, saturation, time_ms, input ready);
  modport sink   (input valid, hue, saturation, time_ms, output ready);
endinterface

interface bhr_rgb_if;
  import bhr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ChanW-1:0]     red;
  logic [ChanW-1:0]     green;
  logic [ChanW-1:0]     blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> src/breathing_hsv_to_rgb.sv
// ----------------------------------------------------------------------------
// breathing_hsv_to_rgb
// Breathing color generator: hue, saturation and time in, one RGB word out.
// ----------------------------------------------------------------------------
// Each input word (hue, saturation, 16-bit millisecond time) yields exactly
// one RGB word. Brightness follows a smooth cubic ease between 80 and 208,
// set by bits 11..4 of time_ms, so the breathing cycle repeats every 4096 ms;
// zero saturation gives gray at that brightness. The block keeps no state
// between words. It is a four-stage pipeline: one word can be accepted every
// clock while rgb_o.ready is high; each word passes through stages 1 to 4,
// and rgb_o.valid rises once stage 4 holds its result.
// The depth is set by the chain of 8x8 multiplies
// (square, cube, then the p/q/t scaling), each followed by a register. When
// the output is stalled, empty stages still fill, so up to four words can be
// in flight; hsv_i.ready drops only when every stage holds a word.
// Whenever rgb_o.ready is high, hsv_i.ready is high in the same cycle.
// ----------------------------------------------------------------------------
module breathing_hsv_to_rgb (
  input  logic        clk_i,
  input  logic        rst_ni,
  bhr_hsv_if.sink     hsv_i,
  bhr_rgb_if.source   rgb_o
);
  import bhr_pkg::*;

  stage_load_t        load;
  logic [ChanW-1:0]   level;      // brightness, aligned with stage 3

  // Valid bits and load enables
  bhr_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hsv_i.valid),
    .in_ready_o  (hsv_i.ready),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .load_o      (load)
  );

  // Stages 1-3: phase fold, square, cube, ease
  bhr_level u_level (
    .clk_i     (clk_i),
    .load_i    (load),
    .time_ms_i (hsv_i.time_ms),
    .level_o   (level)
  );

  // Stages 1-4: hue region and products, final scaling and channel select
  bhr_chroma u_chroma (
    .clk_i   (clk_i),
    .load_i  (load),
    .hue_i   (hsv_i.hue),
    .sat_i   (hsv_i.saturation),
    .level_i (level),
    .red_o   (rgb_o.red),
    .green_o (rgb_o.green),
    .blue_o  (rgb_o.blue)
  );

endmodule

>>> src/bhr_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// bhr_pipe_ctrl
// Valid bits and bubble-collapsing load enables for the datapath stages.
// ----------------------------------------------------------------------------
module bhr_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bhr_pkg::stage_load_t load_o
);
  import bhr_pkg::*;

  logic [NumStages-1:0] valid_q, valid_d, rdy;

  // A stage loads when it is empty or its successor loads too.
  always_comb begin
    rdy[NumStages-1] = ~valid_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign load_o.s1   = rdy[0];
  assign load_o.s2   = rdy[1];
  assign load_o.s3   = rdy[2];
  assign load_o.s4   = rdy[3];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

>>> src/bhr_level.sv
// ----------------------------------------------------------------------------
// bhr_level
// Breathing brightness: triangle phase, then cubic ease, over three stages.
// ----------------------------------------------------------------------------
module bhr_level (
  input  logic                        clk_i,
  input  bhr_pkg::stage_load_t        load_i,
  input  logic [bhr_pkg::TimeW-1:0]   time_ms_i,
  output logic [bhr_pkg::ChanW-1:0]   level_o
);
  import bhr_pkg::*;

  // stage 1: phase fold and square
  logic [ChanW-1:0]   phase, fold, x_d, sq_d;
  logic [2*ChanW-1:0] sq_full;
  logic [ChanW-1:0]   x1_q, sq1_q;

  // stage 2: cube
  logic [2*ChanW-1:0] cu_full;
  logic [ChanW-1:0]   cu_d, sq2_q, cu2_q;

  // stage 3: ease sum
  logic [ChanW+1:0]   ease;
  logic [ChanW-1:0]   level_d, level_q;

  always_comb begin
    phase   = time_ms_i[PhaseLsb +: ChanW];
    fold    = phase[ChanW-1] ? ~phase : phase;   // 255 - phase
    x_d     = {fold[ChanW-2:0], 1'b0};
    sq_full = x_d * x_d;
    sq_d    = sq_full[2*ChanW-1:ChanW];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s1) begin
      x1_q  <= x_d;
      sq1_q <= sq_d;
    end
  end

  always_comb begin
    cu_full = sq1_q * x1_q;
    cu_d    = cu_full[2*ChanW-1:ChanW];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s2) begin
      sq2_q <= sq1_q;
      cu2_q <= cu_d;
    end
  end

  // 3*sq - 2*cu never goes negative since cu <= sq; halved it stays <= 128
  always_comb begin
    ease    = {1'b0, sq2_q, 1'b0} + {2'b00, sq2_q} - {1'b0, cu2_q, 1'b0};
    level_d = ease[ChanW:1] + LevelBase;
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s3) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

>>> src/bhr_chroma.sv
// ----------------------------------------------------------------------------
// bhr_chroma
// Hue region, p/q/t scaling and channel select; holds the output word.
// ----------------------------------------------------------------------------
module bhr_chroma (
  input  logic                        clk_i,
  input  bhr_pkg::stage_load_t        load_i,
  input  logic [bhr_pkg::ChanW-1:0]   hue_i,
  input  logic [bhr_pkg::ChanW-1:0]   sat_i,
  input  logic [bhr_pkg::ChanW-1:0]   level_i,   // aligned with stage 3
  output logic [bhr_pkg::ChanW-1:0]   red_o,
  output logic [bhr_pkg::ChanW-1:0]   green_o,
  output logic [bhr_pkg::ChanW-1:0]   blue_o
);
  import bhr_pkg::*;

  // stage 1
  logic [ChanW+2:0]   hue6;
  hue_region_e        rgn1_q;
  logic [ChanW-1:0]   frac1_q, sat1_q;

  // stage 2
  logic [ChanW-1:0]   frac_n;
  logic [2*ChanW-1:0] sf_full, sfn_full;
  hue_region_e        rgn2_q;
  logic [ChanW-1:0]   sat2_q, sf2_q, sfn2_q;

  // stage 3
  hue_region_e        rgn3_q;
  logic               gray3_q;
  logic [ChanW-1:0]   pi3_q, qi3_q, ti3_q;

  // stage 4
  logic [2*ChanW-1:0] p_full, q_full, t_full;
  logic [ChanW-1:0]   p, q, t;
  logic [ChanW-1:0]   red_d, green_d, blue_d, red_q, green_q, blue_q;

  assign hue6 = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  always_ff @(posedge clk_i) begin
    if (load_i.s1) begin
      rgn1_q  <= hue_region_e'(hue6[ChanW+2:ChanW]);
      frac1_q <= hue6[ChanW-1:0];
      sat1_q  <= sat_i;
    end
  end

  always_comb begin
    frac_n   = ~frac1_q;              // 255 - frac, kept at 8 bits
    sf_full  = sat1_q * frac1_q;
    sfn_full = sat1_q * frac_n;
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s2) begin
      rgn2_q <= rgn1_q;
      sat2_q <= sat1_q;
      sf2_q  <= sf_full[2*ChanW-1:ChanW];
      sfn2_q <= sfn_full[2*ChanW-1:ChanW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s3) begin
      rgn3_q  <= rgn2_q;
      gray3_q <= (sat2_q == '0);
      pi3_q   <= ~sat2_q;
      qi3_q   <= ~sf2_q;
      ti3_q   <= ~sfn2_q;
    end
  end

  always_comb begin
    p_full = level_i * pi3_q;
    q_full = level_i * qi3_q;
    t_full = level_i * ti3_q;
    p      = p_full[2*ChanW-1:ChanW];
    q      = q_full[2*ChanW-1:ChanW];
    t      = t_full[2*ChanW-1:ChanW];
    case (rgn3_q)
      RgnRedYellow:   begin red_d = level_i; green_d = t;       blue_d = p;       end
      RgnYellowGreen: begin red_d = q;       green_d = level_i; blue_d = p;       end
      RgnGreenCyan:   begin red_d = p;       green_d = level_i; blue_d = t;       end
      RgnCyanBlue:    begin red_d = p;       green_d = q;       blue_d = level_i; end
      RgnBlueMagenta: begin red_d = t;       green_d = p;       blue_d = level_i; end
      default:        begin red_d = level_i; green_d = p;       blue_d = q;       end
    endcase
    if (gray3_q) begin
      red_d   = level_i;
      green_d = level_i;
      blue_d  = level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s4) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

>>> src/bhr_checker.sv
// ----------------------------------------------------------------------------
// bhr_checker
// Port-level checks for breathing_hsv_to_rgb, attached by bind.
// ----------------------------------------------------------------------------
module bhr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [bhr_pkg::ChanW-1:0] red_i,
  input logic [bhr_pkg::ChanW-1:0] green_i,
  input logic [bhr_pkg::ChanW-1:0] blue_i
);
  import bhr_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_i;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_i)
      && $stable(green_i) && $stable(blue_i))
    else $error("output word changed while stalled");

  // brightest channel equals the eased level, which stays in 80..208
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (red_i >= 8'd80 || green_i >= 8'd80 || blue_i >= 8'd80)
      && red_i <= 8'd208 && green_i <= 8'd208 && blue_i <= 8'd208)
    else $error("output brightness out of range");

  // a ready output side never back-pressures the input
  a_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output ready");

  // with nothing entering and the output draining, the pipe empties
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3) && !$past(in_acc, 4)
      && $past(out_ready_i, 1) && $past(out_ready_i, 2) && $past(out_ready_i, 3)
      && $past(out_ready_i, 4) |-> !out_valid_i)
    else $error("output word without a matching input word");

endmodule

bind breathing_hsv_to_rgb bhr_checker u_bhr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hsv_i.valid),
  .in_ready_i  (hsv_i.ready),
  .out_valid_i (rgb_o.valid),
  .out_ready_i (rgb_o.ready),
  .red_i       (rgb_o.red),
  .green_i     (rgb_o.green),
  .blue_i      (rgb_o.blue)
);

>>> tb/breathing_hsv_to_rgb_checker.sv
// ----------------------------------------------------------------------------
// breathing_hsv_to_rgb_checker
// Watches both channels of the breathing color block, predicts each RGB word
// from the accepted HSV-plus-time word and compares it in order of arrival.
// ----------------------------------------------------------------------------
module breathing_hsv_to_rgb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bhr_hsv_if   hsv_i,
  bhr_rgb_if   rgb_i,
  output int   errors_o,
  output int   pending_o
);
  import bhr_pkg::*;

  localparam int MaxReports = 10;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_word_t;

  rgb_word_t expected_rgb_q[$];
  int        error_cnt = 0;

  // Breathing level from time, then integer HSV to RGB at that level
  function automatic rgb_word_t calc_rgb(input logic [ChanW-1:0] hue,
                                         input logic [ChanW-1:0] sat,
                                         input logic [TimeW-1:0] t);
    logic [ChanW-1:0] phase, x, sq, cu, lvl, frac, p, q, tt;
    logic [15:0]      prod, scaled;
    logic [9:0]       ease;
    logic [10:0]      hue6;
    hue_region_e      rgn;
    rgb_word_t        w;
    phase = t[PhaseLsb +: ChanW];
    if (phase[ChanW-1]) begin
      phase = 8'd255 - phase;     // fold into a triangle
    end
    x    = {phase[ChanW-2:0], 1'b0};
    prod = x * x;
    sq   = prod[15:8];
    prod = sq * x;
    cu   = prod[15:8];
    ease = 10'(3 * sq - 2 * cu);
    lvl  = ease[8:1] + LevelBase;
    if (sat == '0) begin
      w = '{lvl, lvl, lvl};
    end else begin
      hue6   = 11'(hue * 6);
      rgn    = hue_region_e'(hue6[10:8]);
      frac   = hue6[7:0];
      prod   = lvl * (8'd255 - sat);
      p      = prod[15:8];
      scaled = sat * frac;
      prod   = lvl * (8'd255 - scaled[15:8]);
      q      = prod[15:8];
      scaled = sat * (8'd255 - frac);
      prod   = lvl * (8'd255 - scaled[15:8]);
      tt     = prod[15:8];
      case (rgn)
        RgnRedYellow:   w = '{lvl, tt, p};
        RgnYellowGreen: w = '{q, lvl, p};
        RgnGreenCyan:   w = '{p, lvl, tt};
        RgnCyanBlue:    w = '{p, q, lvl};
        RgnBlueMagenta: w = '{tt, p, lvl};
        default:        w = '{lvl, p, q};  // magenta to red
      endcase
    end
    return w;
  endfunction

  always @(posedge clk_i) begin
    rgb_word_t seen, want;
    if (rst_ni) begin
      if (hsv_i.valid && hsv_i.ready) begin
        expected_rgb_q.push_back(calc_rgb(hsv_i.hue, hsv_i.saturation, hsv_i.time_ms));
      end
      if (rgb_i.valid && rgb_i.ready) begin
        seen = '{rgb_i.red, rgb_i.green, rgb_i.blue};
        if (expected_rgb_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MaxReports) begin
            $display("%0t: unexpected rgb word r=%0d g=%0d b=%0d", $time,
                     seen.red, seen.green, seen.blue);
          end
        end else begin
          want = expected_rgb_q.pop_front();
          if (seen.red !== want.red || seen.green !== want.green ||
              seen.blue !== want.blue) begin
            error_cnt++;
            if (error_cnt <= MaxReports) begin
              $display("%0t: rgb mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $time, want.red, want.green, want.blue,
                       seen.red, seen.green, seen.blue);
            end
          end
        end
      end
    end
    errors_o  <= error_cnt;
    pending_o <= expected_rgb_q.size();
  end

endmodule

>>> tb/breathing_hsv_to_rgb_tb.sv
// ----------------------------------------------------------------------------
// breathing_hsv_to_rgb_tb
// Drives HSV-plus-time words into the breathing color block under random
// backpressure and lets a side checker compare every RGB word it returns.
// ----------------------------------------------------------------------------
module breathing_hsv_to_rgb_tb;
  import bhr_pkg::*;

  // Long output hold-off; far more than the four pipeline stages, so the
  // block fills up and drops its input ready for most of it.
  localparam int HoldCycles  = 200;
  // Settle time after the last expected word.
  localparam int DrainCycles = NumStages * 4;
  // Worst case for the ~710 words is about 156k time units; the limit is over
  // six times that.
  localparam int TimeoutTu   = 1_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   errors;
  int   pending;

  // Receiver control: hold requests are counted by the stimulus and served by
  // the receiver process, so each variable has a single writer.
  int   hold_req_cnt  = 0;
  int   hold_done_cnt = 0;
  logic rx_holding    = 1'b0;
  logic rx_steady     = 1'b0;

  bhr_hsv_if hsv_ch ();
  bhr_rgb_if rgb_ch ();

  breathing_hsv_to_rgb u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .hsv_i  (hsv_ch),
    .rgb_o  (rgb_ch)
  );

  breathing_hsv_to_rgb_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .hsv_i     (hsv_ch),
    .rgb_i     (rgb_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(3, 1);
    end else if (r < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(50, 20);
  endfunction

  // Offer one word and hold it until taken. valid is only dropped when a gap
  // follows, so back-to-back words keep it high without a glitch.
  task automatic offer(input logic [ChanW-1:0] hue, input logic [ChanW-1:0] sat,
                       input logic [TimeW-1:0] t, input bit paced);
    int unsigned gap;
    hsv_ch.valid      <= 1'b1;
    hsv_ch.hue        <= hue;
    hsv_ch.saturation <= sat;
    hsv_ch.time_ms    <= t;
    do @(posedge clk); while (!hsv_ch.ready);
    gap = paced ? pick_gap() : 0;
    if (gap != 0) begin
      hsv_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random words; saturation leans on 0, 1 and 255, and a share of the
  // times land on the fold points of the breathing phase.
  task automatic run_random(input int count, input bit paced);
    logic [ChanW-1:0] hue, sat;
    logic [TimeW-1:0] t;
    int unsigned      r;
    for (int i = 0; i < count; i++) begin
      hue = 8'($urandom_range(255));
      r   = $urandom_range(99);
      if (r < 10) begin
        sat = '0;
      end else if (r < 15) begin
        sat = 8'd255;
      end else if (r < 20) begin
        sat = 8'd1;
      end else begin
        sat = 8'($urandom_range(255));
      end
      t = 16'($urandom_range(16'hFFFF));
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(5))
          0:       t[PhaseLsb +: ChanW] = 8'h00;
          1:       t[PhaseLsb +: ChanW] = 8'h7E;
          2:       t[PhaseLsb +: ChanW] = 8'h7F;
          3:       t[PhaseLsb +: ChanW] = 8'h80;
          4:       t[PhaseLsb +: ChanW] = 8'h81;
          default: t[PhaseLsb +: ChanW] = 8'hFF;
        endcase
      end
      offer(hue, sat, t, paced);
    end
  endtask

  // Checker's pending count is registered, so always wait on the clock before testing it
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // Output side: random stalls, steady ready on request, or a long hold
  initial begin
    int unsigned stall;
    rgb_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req_cnt != hold_done_cnt) begin
        rx_holding = 1'b1;
        rgb_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        rx_holding = 1'b0;
        hold_done_cnt++;
      end else if (rx_steady) begin
        rgb_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          rgb_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        rgb_ch.ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    hsv_ch.valid      <= 1'b0;
    hsv_ch.hue        <= '0;
    hsv_ch.saturation <= '0;
    hsv_ch.time_ms    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Gray at the brightness floor, at the peak from both sides of the fold,
    // and at the phase wrap
    offer(8'd0,   8'd0,   16'h0000, 1'b1);
    offer(8'd255, 8'd0,   16'h07F0, 1'b1);
    offer(8'd0,   8'd0,   16'h0800, 1'b1);
    offer(8'd17,  8'd0,   16'h0FF0, 1'b1);
    // Full saturation through every hue region, first and last hue of red
    // to yellow (zero and largest fraction), and the top hue
    offer(8'd0,   8'd255, 16'h0400, 1'b1);
    offer(8'd42,  8'd255, 16'h0400, 1'b1);
    offer(8'd43,  8'd255, 16'h0520, 1'b1);
    offer(8'd86,  8'd255, 16'h0640, 1'b1);
    offer(8'd128, 8'd255, 16'h07F0, 1'b1);
    offer(8'd171, 8'd255, 16'h0A00, 1'b1);
    offer(8'd214, 8'd255, 16'h0C30, 1'b1);
    offer(8'd255, 8'd255, 16'hFFFF, 1'b1);
    // Smallest nonzero and near-full saturation
    offer(8'd200, 8'd1,   16'h0123, 1'b1);
    offer(8'd100, 8'd254, 16'h0345, 1'b1);
    // High time bits must not move the phase
    offer(8'd85,  8'd128, 16'hF7F0, 1'b1);
    offer(8'd85,  8'd128, 16'h07F0, 1'b1);
    offer(8'd170, 8'd64,  16'h8000, 1'b1);
    offer(8'd60,  8'd200, 16'h0010, 1'b1);
    offer(8'd150, 8'd99,  16'h5A5A, 1'b1);
    offer(8'd233, 8'd170, 16'hA5A5, 1'b1);

    run_random(250, 1'b1);
    hsv_ch.valid <= 1'b0;

    // Output held off while words keep coming: pipeline fills, input stalls
    hold_req_cnt++;
    while (!rx_holding) @(posedge clk);
    run_random(40, 1'b0);
    hsv_ch.valid <= 1'b0;
    wait_drained();

    // Full rate, no idling on either side
    rx_steady = 1'b1;
    run_random(150, 1'b0);
    rx_steady = 1'b0;

    run_random(250, 1'b1);
    hsv_ch.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #TimeoutTu;
    $display("Some tests failed");
    $finish;
  end

endmodule
